[rtl/dhfk_pkg.sv]
// ----------------------------------------------------------------------------
// dhfk_pkg
// Shared types, constants and helpers of the DH forward kinematics block.
// ----------------------------------------------------------------------------
package dhfk_pkg;

   localparam int MAX_JOINTS        = 8;
   localparam int JOINT_SLOTS       = (MAX_JOINTS < 8) ? MAX_JOINTS : 8;
   localparam int CORDIC_ITERATIONS = 16;
   localparam int CORDIC_STEPS      = (CORDIC_ITERATIONS < 1)  ? 1 :
                                      (CORDIC_ITERATIONS > 30) ? 30 : CORDIC_ITERATIONS;

   // memory geometry: DH words, then joint-to-link and base-to-link matrices
   localparam int DH_DEPTH  = JOINT_SLOTS * 4;
   localparam int DH_AW     = (DH_DEPTH > 1) ? $clog2(DH_DEPTH) : 1;
   localparam int MAT_WORDS = 12;
   localparam int BT_BASE   = JOINT_SLOTS * MAT_WORDS;
   localparam int MAT_DEPTH = 2 * BT_BASE;
   localparam int MAT_AW    = $clog2(MAT_DEPTH);

   localparam logic [3:0] SLOT_LIMIT = 4'(JOINT_SLOTS);

   localparam logic signed [31:0] DEG_TO_RAD_Q32  = 32'sd74961321;
   localparam logic signed [31:0] RAD_TO_TURN_Q16 = 32'sd683565276;
   localparam logic signed [33:0] CORDIC_GAIN_Q30 = 34'sd652032874;
   localparam logic signed [31:0] Q16_MAX         = 32'sh7FFF_FFFF;
   localparam logic signed [31:0] Q16_MIN         = 32'sh8000_0000;

   localparam logic [1:0] MODE_LOAD  = 2'd0;
   localparam logic [1:0] MODE_ANGLE = 2'd1;
   localparam logic [1:0] MODE_CHAIN = 2'd2;

   localparam logic [1:0] FIELD_D      = 2'd0;
   localparam logic [1:0] FIELD_A      = 2'd1;
   localparam logic [1:0] FIELD_ALPHA  = 2'd2;
   localparam logic [1:0] FIELD_OFFSET = 2'd3;

   localparam logic [1:0] ROW_LAST = 2'd2;

   typedef struct packed {
      logic [1:0]         mode;
      logic [2:0]         joint_index;
      logic [1:0]         dh_field;
      logic signed [31:0] value;
   } req_type;

   typedef struct packed {
      logic [2:0]         out_joint;
      logic [1:0]         out_row;
      logic signed [31:0] col0;
      logic signed [31:0] col1;
      logic signed [31:0] col2;
      logic signed [31:0] col3;
      logic               last;
   } rsp_type;

   typedef struct packed {
      logic mul;    // load product register
      logic init;   // accumulator takes the init value
      logic add;    // accumulator adds the rounded product
   } mac_ctl_type;

   function automatic logic signed [31:0] sat32(input logic signed [49:0] v);
      logic signed [31:0] r;
      if (v > 50'(Q16_MAX))       r = Q16_MAX;
      else if (v < 50'(Q16_MIN))  r = Q16_MIN;
      else                        r = v[31:0];
      return r;
   endfunction

   // arctangent of 2^-i in binary turns (full turn = 2^32)
   function automatic logic signed [33:0] cordic_atan(input logic [4:0] idx);
      logic signed [33:0] r;
      case (idx)
         5'd0:  r = 34'sd536870912;
         5'd1:  r = 34'sd316933406;
         5'd2:  r = 34'sd167458907;
         5'd3:  r = 34'sd85004756;
         5'd4:  r = 34'sd42667331;
         5'd5:  r = 34'sd21354465;
         5'd6:  r = 34'sd10679838;
         5'd7:  r = 34'sd5340245;
         5'd8:  r = 34'sd2670163;
         5'd9:  r = 34'sd1335087;
         5'd10: r = 34'sd667544;
         5'd11: r = 34'sd333772;
         5'd12: r = 34'sd166886;
         5'd13: r = 34'sd83443;
         5'd14: r = 34'sd41722;
         5'd15: r = 34'sd20861;
         5'd16: r = 34'sd10430;
         5'd17: r = 34'sd5215;
         5'd18: r = 34'sd2608;
         5'd19: r = 34'sd1304;
         5'd20: r = 34'sd652;
         5'd21: r = 34'sd326;
         5'd22: r = 34'sd163;
         5'd23: r = 34'sd81;
         5'd24: r = 34'sd41;
         5'd25: r = 34'sd20;
         5'd26: r = 34'sd10;
         5'd27: r = 34'sd5;
         5'd28: r = 34'sd3;
         5'd29: r = 34'sd1;
         default: r = 34'sd0;
      endcase
      return r;
   endfunction

endpackage

[rtl/dhfk_ram.sv]
// ----------------------------------------------------------------------------
// dhfk_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module dhfk_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 32
) (
   input  logic                                   clock,
   input  logic                                   we,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
   input  logic [WIDTH-1:0]                       wdata,
   input  logic                                   re,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
   output logic [WIDTH-1:0]                       rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

[rtl/dhfk_cordic.sv]
// ----------------------------------------------------------------------------
// dhfk_cordic
// Iterative CORDIC sine/cosine, Q16.16 radians in, Q16.16 out.
// ----------------------------------------------------------------------------
module dhfk_cordic import dhfk_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic signed [31:0] angle,
   output logic               done,
   output logic signed [31:0] sin_q,
   output logic signed [31:0] cos_q
);

   typedef enum logic [3:0] {
      C_IDLE = 4'b0001,
      C_TURN = 4'b0010,
      C_ITER = 4'b0100,
      C_DONE = 4'b1000
   } cstate_type;

   cstate_type         state_ff, state_in;
   logic signed [63:0] turn_ff, turn_in;
   logic signed [33:0] x_ff, x_in, y_ff, y_in, z_ff, z_in;
   logic               flip_ff, flip_in;
   logic [4:0]         i_ff, i_in;

   logic signed [63:0] q;
   logic [31:0]        u;
   logic signed [33:0] dx, dy, xr, yr;

   always_comb begin
      state_in = state_ff;
      turn_in  = turn_ff;
      x_in     = x_ff;
      y_in     = y_ff;
      z_in     = z_ff;
      flip_in  = flip_ff;
      i_in     = i_ff;
      q        = turn_ff >>> 16;
      u        = q[31:0];
      dx       = y_ff >>> i_ff;
      dy       = x_ff >>> i_ff;
      xr       = (x_ff + 34'sd8192) >>> 14;
      yr       = (y_ff + 34'sd8192) >>> 14;
      if (flip_ff) begin
         xr = -xr;
         yr = -yr;
      end
      case (state_ff)
         C_IDLE: begin
            if (start) begin
               turn_in  = 64'(angle) * 64'(RAD_TO_TURN_Q16);
               state_in = C_TURN;
            end
         end
         C_TURN: begin
            // fold the angle into +-90 degrees
            flip_in  = u[31] ^ u[30];
            z_in     = (u[31] ^ u[30]) ? 34'(signed'({~u[31], u[30:0]}))
                                       : 34'(signed'(u));
            x_in     = CORDIC_GAIN_Q30;
            y_in     = '0;
            i_in     = '0;
            state_in = C_ITER;
         end
         C_ITER: begin
            if (!z_ff[33]) begin
               x_in = x_ff - dx;
               y_in = y_ff + dy;
               z_in = z_ff - cordic_atan(i_ff);
            end else begin
               x_in = x_ff + dx;
               y_in = y_ff - dy;
               z_in = z_ff + cordic_atan(i_ff);
            end
            i_in = i_ff + 5'd1;
            if (i_ff == 5'(CORDIC_STEPS - 1)) begin
               state_in = C_DONE;
            end
         end
         C_DONE: begin
            state_in = C_IDLE;
         end
         default: begin
            state_in = C_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= C_IDLE;
      end else begin
         state_ff <= state_in;
      end
      turn_ff <= turn_in;
      x_ff    <= x_in;
      y_ff    <= y_in;
      z_ff    <= z_in;
      flip_ff <= flip_in;
      i_ff    <= i_in;
   end

   assign done  = (state_ff == C_DONE);
   assign cos_q = xr[31:0];
   assign sin_q = yr[31:0];

endmodule

[rtl/dhfk_mac.sv]
// ----------------------------------------------------------------------------
// dhfk_mac
// Shared Q16.16 multiply-accumulate: registered product, rounded add.
// ----------------------------------------------------------------------------
module dhfk_mac import dhfk_pkg::*; (
   input  logic               clock,
   input  mac_ctl_type        ctl,
   input  logic signed [31:0] op_a,
   input  logic signed [31:0] op_b,
   input  logic signed [31:0] init_val,
   output logic signed [31:0] acc_sat
);

   logic signed [63:0] prod_ff, prod_in;
   logic signed [49:0] acc_ff, acc_in;
   logic signed [63:0] term;

   always_comb begin
      prod_in = 64'(op_a) * 64'(op_b);
      term    = (prod_ff + 64'sd32768) >>> 16;
      acc_in  = acc_ff;
      if (ctl.init) begin
         acc_in = 50'(init_val);
      end else if (ctl.add) begin
         acc_in = acc_ff + term[49:0];
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.mul) begin
         prod_ff <= prod_in;
      end
      acc_ff <= acc_in;
   end

   assign acc_sat = sat32(acc_ff);

endmodule

[rtl/dh_forward_kinematics_chain.sv]
// ----------------------------------------------------------------------------
// dh_forward_kinematics_chain
// Denavit-Hartenberg forward kinematics of a serial arm, Q16.16.
// ----------------------------------------------------------------------------
// One item at a time. A DH word load (mode 0) is written to memory on
// accept. A joint angle (mode 1) keeps the block busy after the accept: DH
// word reads, the degree-to-radian product and theta, two CORDIC runs
// (theta, then alpha), then the twelve matrix words through the single shared
// multiplier. A chain update (mode 2) works joint by joint (joint 0 is a
// plain copy), paced by the one read port of the matrix memory and the
// shared multiplier: it fetches the joint transform, and per row fetches the
// previous base row, forms each element and hands the row to the output
// register. Three items come out per joint, the final one of the chain
// flagged by last; the output register stalls the sequencer only when a row
// is still untaken. All DH words and matrices live in RAM with undefined
// power-up contents; no clearing pass is run. csr writes joint_count and is
// always ready.
// ----------------------------------------------------------------------------
module dh_forward_kinematics_chain import dhfk_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  req_type    req_data,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output rsp_type    rsp_data,
   input  logic       csr_valid,
   output logic       csr_ready,
   input  logic [3:0] csr_data
);

   typedef enum logic [12:0] {
      S_IDLE      = 13'b0000000000001,
      S_DH_RD     = 13'b0000000000010,
      S_RAD       = 13'b0000000000100,
      S_THETA     = 13'b0000000001000,
      S_TRIG_GO   = 13'b0000000010000,
      S_TRIG_WAIT = 13'b0000000100000,
      S_JT_MAC    = 13'b0000001000000,
      S_JT_WR     = 13'b0000010000000,
      S_CH_JT     = 13'b0000100000000,
      S_CH_PB     = 13'b0001000000000,
      S_CH_MAC    = 13'b0010000000000,
      S_CH_WR     = 13'b0100000000000,
      S_EMIT      = 13'b1000000000000
   } state_type;

   state_type          state_ff, state_in;
   logic [3:0]         joint_count_ff, joint_count_in;
   logic [3:0]         count_ff, count_in;
   logic [2:0]         cur_ff, cur_in;
   logic signed [31:0] deg_ff, deg_in;
   logic signed [31:0] dh_ff [4];
   logic signed [31:0] dh_in [4];
   logic signed [63:0] rad_prod_ff, rad_prod_in;
   logic signed [31:0] theta_ff, theta_in;
   logic               trig_sel_ff, trig_sel_in;
   logic signed [31:0] s_ff, s_in, c_ff, c_in, sa_ff, sa_in, ca_ff, ca_in;
   logic signed [31:0] jt_ff [12];
   logic signed [31:0] jt_in [12];
   logic signed [31:0] pb_ff [4];
   logic signed [31:0] pb_in [4];
   logic signed [31:0] row_ff [4];
   logic signed [31:0] row_in [4];
   logic [3:0]         cnt_ff, cnt_in;
   logic [3:0]         elem_ff, elem_in;
   logic [1:0]         kk_ff, kk_in;
   logic [1:0]         rowi_ff, rowi_in;
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_type            rsp_ff, rsp_in;

   // memories
   logic               dh_we, dh_re;
   logic [DH_AW-1:0]   dh_waddr, dh_raddr;
   logic [31:0]        dh_rdata;
   logic               mat_we, mat_re;
   logic [MAT_AW-1:0]  mat_waddr, mat_raddr;
   logic [31:0]        mat_wdata, mat_rdata;

   // shared units
   mac_ctl_type        mac_ctl;
   logic signed [31:0] mac_a, mac_b, mac_init, mac_acc, mac_neg;
   logic               cordic_start, cordic_done;
   logic signed [31:0] cordic_angle, cordic_sin, cordic_cos;

   logic               req_fire, slot_ok, start_ok, last_joint, rsp_free;
   logic [3:0]         count_c;
   logic [MAT_AW-1:0]  jt_base, bt_base, pb_base;
   logic signed [63:0] rad;
   logic signed [33:0] theta_sum;
   logic signed [31:0] jt_val, ch_val;
   logic [3:0]         jt_idx;

   assign req_ready = (state_ff == S_IDLE);
   assign csr_ready = 1'b1;
   assign req_fire  = req_valid && req_ready;
   assign rsp_free  = !rsp_valid_ff || rsp_ready;

   assign slot_ok    = 32'(req_data.joint_index) < JOINT_SLOTS;
   assign count_c    = (joint_count_ff > SLOT_LIMIT) ? SLOT_LIMIT : joint_count_ff;
   assign start_ok   = {1'b0, req_data.joint_index} < count_c;
   assign last_joint = (4'(cur_ff) + 4'd1) == count_ff;

   assign jt_base = MAT_AW'(32'(cur_ff) * MAT_WORDS);
   assign bt_base = jt_base + MAT_AW'(BT_BASE);
   assign pb_base = bt_base - MAT_AW'(MAT_WORDS);

   // saturating negate of the accumulator
   assign mac_neg = (mac_acc == Q16_MIN) ? Q16_MAX : -mac_acc;

   // DH word loads go straight to memory on accept
   assign dh_we    = req_fire && (req_data.mode == MODE_LOAD) && slot_ok;
   assign dh_waddr = DH_AW'(32'(req_data.joint_index) * 4 + 32'(req_data.dh_field));

   always_comb begin
      state_in       = state_ff;
      joint_count_in = csr_valid ? csr_data : joint_count_ff;
      count_in       = count_ff;
      cur_in         = cur_ff;
      deg_in         = deg_ff;
      dh_in          = dh_ff;
      rad_prod_in    = rad_prod_ff;
      theta_in       = theta_ff;
      trig_sel_in    = trig_sel_ff;
      s_in           = s_ff;
      c_in           = c_ff;
      sa_in          = sa_ff;
      ca_in          = ca_ff;
      jt_in          = jt_ff;
      pb_in          = pb_ff;
      row_in         = row_ff;
      cnt_in         = cnt_ff;
      elem_in        = elem_ff;
      kk_in          = kk_ff;
      rowi_in        = rowi_ff;
      rsp_in         = rsp_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_ready;

      dh_re        = 1'b0;
      dh_raddr     = DH_AW'(32'(cur_ff) * 4 + 32'(cnt_ff[1:0]));
      mat_we       = 1'b0;
      mat_waddr    = jt_base + MAT_AW'(elem_ff);
      mat_wdata    = '0;
      mat_re       = 1'b0;
      mat_raddr    = jt_base + MAT_AW'(cnt_ff);
      mac_ctl      = '0;
      mac_a        = '0;
      mac_b        = '0;
      mac_init     = '0;
      cordic_start = 1'b0;
      cordic_angle = trig_sel_ff ? dh_ff[FIELD_ALPHA] : theta_ff;

      rad       = (rad_prod_ff + 64'sd2147483648) >>> 32;
      theta_sum = 34'(dh_ff[FIELD_OFFSET]) + rad[33:0];
      jt_idx    = {((kk_ff == 2'd3) ? 2'd0 : kk_ff), elem_ff[1:0]};
      ch_val    = (cur_ff == 3'd0) ? jt_ff[{rowi_ff, elem_ff[1:0]}] : mac_acc;

      // joint-to-link words: direct trig terms, the d offset, zero or one rounded product
      case (elem_ff)
         4'd0:    jt_val = c_ff;
         4'd1:    jt_val = mac_neg;
         4'd2:    jt_val = mac_acc;
         4'd3:    jt_val = mac_acc;
         4'd4:    jt_val = s_ff;
         4'd5:    jt_val = mac_acc;
         4'd6:    jt_val = mac_neg;
         4'd7:    jt_val = mac_acc;
         4'd9:    jt_val = sa_ff;
         4'd10:   jt_val = ca_ff;
         4'd11:   jt_val = dh_ff[FIELD_D];
         default: jt_val = '0;
      endcase

      case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               case (req_data.mode)
                  MODE_ANGLE: begin
                     if (slot_ok) begin
                        cur_in   = req_data.joint_index;
                        deg_in   = req_data.value;
                        cnt_in   = '0;
                        state_in = S_DH_RD;
                     end
                  end
                  MODE_CHAIN: begin
                     if (start_ok) begin
                        cur_in   = req_data.joint_index;
                        count_in = count_c;
                        cnt_in   = '0;
                        rowi_in  = '0;
                        state_in = S_CH_JT;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         S_DH_RD: begin
            dh_re = (cnt_ff < 4'd4);
            if (cnt_ff != 4'd0) begin
               dh_in[2'(cnt_ff - 4'd1)] = dh_rdata;
            end
            cnt_in = cnt_ff + 4'd1;
            if (cnt_ff == 4'd4) begin
               state_in = S_RAD;
            end
         end
         S_RAD: begin
            rad_prod_in = 64'(deg_ff) * 64'(DEG_TO_RAD_Q32);
            state_in    = S_THETA;
         end
         S_THETA: begin
            theta_in    = sat32(50'(theta_sum));
            trig_sel_in = 1'b0;
            state_in    = S_TRIG_GO;
         end
         S_TRIG_GO: begin
            cordic_start = 1'b1;
            state_in     = S_TRIG_WAIT;
         end
         S_TRIG_WAIT: begin
            if (cordic_done) begin
               if (!trig_sel_ff) begin
                  s_in        = cordic_sin;
                  c_in        = cordic_cos;
                  trig_sel_in = 1'b1;
                  state_in    = S_TRIG_GO;
               end else begin
                  sa_in    = cordic_sin;
                  ca_in    = cordic_cos;
                  elem_in  = '0;
                  kk_in    = '0;
                  state_in = S_JT_MAC;
               end
            end
         end
         S_JT_MAC: begin
            case (elem_ff)
               4'd1:    begin mac_a = s_ff;         mac_b = ca_ff; end
               4'd2:    begin mac_a = s_ff;         mac_b = sa_ff; end
               4'd3:    begin mac_a = dh_ff[FIELD_A]; mac_b = c_ff; end
               4'd5:    begin mac_a = c_ff;         mac_b = ca_ff; end
               4'd6:    begin mac_a = c_ff;         mac_b = sa_ff; end
               4'd7:    begin mac_a = dh_ff[FIELD_A]; mac_b = s_ff; end
               default: begin mac_a = '0;           mac_b = '0;    end
            endcase
            if (elem_ff == 4'd1 || elem_ff == 4'd2 || elem_ff == 4'd3 ||
                elem_ff == 4'd5 || elem_ff == 4'd6 || elem_ff == 4'd7) begin
               if (kk_ff == 2'd0) begin
                  mac_ctl.mul  = 1'b1;
                  mac_ctl.init = 1'b1;
                  kk_in        = 2'd1;
               end else begin
                  mac_ctl.add = 1'b1;
                  kk_in       = 2'd0;
                  state_in    = S_JT_WR;
               end
            end else begin
               state_in = S_JT_WR;
            end
         end
         S_JT_WR: begin
            mat_we    = 1'b1;
            mat_waddr = jt_base + MAT_AW'(elem_ff);
            mat_wdata = jt_val;
            elem_in   = elem_ff + 4'd1;
            state_in  = (elem_ff == 4'(MAT_WORDS - 1)) ? S_IDLE : S_JT_MAC;
         end
         S_CH_JT: begin
            mat_re    = (cnt_ff < 4'(MAT_WORDS));
            mat_raddr = jt_base + MAT_AW'(cnt_ff);
            if (cnt_ff != 4'd0) begin
               jt_in[cnt_ff - 4'd1] = mat_rdata;
            end
            if (cnt_ff == 4'(MAT_WORDS)) begin
               cnt_in   = '0;
               state_in = S_CH_PB;
            end else begin
               cnt_in = cnt_ff + 4'd1;
            end
         end
         S_CH_PB: begin
            if (cur_ff == 3'd0) begin
               elem_in  = '0;
               kk_in    = '0;
               state_in = S_CH_MAC;
            end else begin
               mat_re    = (cnt_ff < 4'd4);
               mat_raddr = pb_base + MAT_AW'({rowi_ff, cnt_ff[1:0]});
               if (cnt_ff != 4'd0) begin
                  pb_in[2'(cnt_ff - 4'd1)] = mat_rdata;
               end
               if (cnt_ff == 4'd4) begin
                  cnt_in   = '0;
                  elem_in  = '0;
                  kk_in    = '0;
                  state_in = S_CH_MAC;
               end else begin
                  cnt_in = cnt_ff + 4'd1;
               end
            end
         end
         S_CH_MAC: begin
            if (cur_ff == 3'd0) begin
               state_in = S_CH_WR;
            end else begin
               // translation column starts from the previous translation
               mac_a        = pb_ff[kk_ff];
               mac_b        = jt_ff[jt_idx];
               mac_init     = (elem_ff == 4'd3) ? pb_ff[3] : '0;
               mac_ctl.mul  = (kk_ff != 2'd3);
               mac_ctl.init = (kk_ff == 2'd0);
               mac_ctl.add  = (kk_ff != 2'd0);
               if (kk_ff == 2'd3) begin
                  kk_in    = '0;
                  state_in = S_CH_WR;
               end else begin
                  kk_in = kk_ff + 2'd1;
               end
            end
         end
         S_CH_WR: begin
            mat_we                 = 1'b1;
            mat_waddr              = bt_base + MAT_AW'({rowi_ff, elem_ff[1:0]});
            mat_wdata              = ch_val;
            row_in[elem_ff[1:0]]   = ch_val;
            if (elem_ff == 4'd3) begin
               state_in = S_EMIT;
            end else begin
               elem_in  = elem_ff + 4'd1;
               state_in = S_CH_MAC;
            end
         end
         S_EMIT: begin
            if (rsp_free) begin
               rsp_valid_in     = 1'b1;
               rsp_in.out_joint = cur_ff;
               rsp_in.out_row   = rowi_ff;
               rsp_in.col0      = row_ff[0];
               rsp_in.col1      = row_ff[1];
               rsp_in.col2      = row_ff[2];
               rsp_in.col3      = row_ff[3];
               rsp_in.last      = last_joint && (rowi_ff == ROW_LAST);
               cnt_in           = '0;
               if (rowi_ff == ROW_LAST) begin
                  rowi_in = '0;
                  if (last_joint) begin
                     state_in = S_IDLE;
                  end else begin
                     cur_in   = cur_ff + 3'd1;
                     state_in = S_CH_JT;
                  end
               end else begin
                  rowi_in  = rowi_ff + 2'd1;
                  state_in = S_CH_PB;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= S_IDLE;
         joint_count_ff <= 4'd7;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         joint_count_ff <= joint_count_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
      count_ff    <= count_in;
      cur_ff      <= cur_in;
      deg_ff      <= deg_in;
      dh_ff       <= dh_in;
      rad_prod_ff <= rad_prod_in;
      theta_ff    <= theta_in;
      trig_sel_ff <= trig_sel_in;
      s_ff        <= s_in;
      c_ff        <= c_in;
      sa_ff       <= sa_in;
      ca_ff       <= ca_in;
      jt_ff       <= jt_in;
      pb_ff       <= pb_in;
      row_ff      <= row_in;
      cnt_ff      <= cnt_in;
      elem_ff     <= elem_in;
      kk_ff       <= kk_in;
      rowi_ff     <= rowi_in;
      rsp_ff      <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   dhfk_ram #(.WIDTH(32), .DEPTH(DH_DEPTH)) u_dh_ram (
      .clock (clock),
      .we    (dh_we),
      .waddr (dh_waddr),
      .wdata (req_data.value),
      .re    (dh_re),
      .raddr (dh_raddr),
      .rdata (dh_rdata)
   );

   dhfk_ram #(.WIDTH(32), .DEPTH(MAT_DEPTH)) u_mat_ram (
      .clock (clock),
      .we    (mat_we),
      .waddr (mat_waddr),
      .wdata (mat_wdata),
      .re    (mat_re),
      .raddr (mat_raddr),
      .rdata (mat_rdata)
   );

   dhfk_cordic u_cordic (
      .clock (clock),
      .reset (reset),
      .start (cordic_start),
      .angle (cordic_angle),
      .done  (cordic_done),
      .sin_q (cordic_sin),
      .cos_q (cordic_cos)
   );

   dhfk_mac u_mac (
      .clock    (clock),
      .ctl      (mac_ctl),
      .op_a     (mac_a),
      .op_b     (mac_b),
      .init_val (mac_init),
      .acc_sat  (mac_acc)
   );

`ifndef SYNTHESIS
   // chain updates only ever write the base-to-link region
   a_chain_wr_region: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_CH_WR) |-> (32'(mat_waddr) >= BT_BASE))
      else $error("chain write outside base-to-link region");

   // a pending untaken row holds the sequencer in the emit state
   a_emit_stall: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_EMIT && rsp_valid_ff && !rsp_ready) |=> (state_ff == S_EMIT))
      else $error("row emitted over an untaken item");

   // last flag only on the final row
   a_last_row: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ff.last) |-> (rsp_ff.out_row == ROW_LAST))
      else $error("last flag on a row other than the final one");

   // chain request at or above the joint count produces nothing
   a_chain_empty: assert property (@(posedge clock) disable iff (reset)
      (req_fire && req_data.mode == MODE_CHAIN && !start_ok) |=> (state_ff == S_IDLE))
      else $error("empty chain request started work");

   // CORDIC is only started when the sequencer is waiting for no result
   a_cordic_start: assert property (@(posedge clock) disable iff (reset)
      cordic_start |=> (state_ff == S_TRIG_WAIT && !cordic_done))
      else $error("CORDIC start out of sequence");
`endif

endmodule

[tb/dh_forward_kinematics_chain_tb.sv]
// ----------------------------------------------------------------------------
// dh_forward_kinematics_chain_tb
// Self-checking bench: DH loads, joint angles and chain updates are predicted
// in fixed point and every emitted row is compared against the prediction.
// ----------------------------------------------------------------------------
module dh_forward_kinematics_chain_tb import dhfk_pkg::*;;
   timeunit 1ns;
   timeprecision 1ps;

   // mode code the block does not use; such items are dropped
   localparam logic [1:0] MODE_SPARE = 2'd3;

   // --------------------------------------------------------------------
   // scoreboard: own copy of DH table and matrices, queue of due rows
   // --------------------------------------------------------------------
   class fk_scoreboard;
      int unsigned joint_lim;
      int          dh_words[JOINT_SLOTS*4];
      int          link_mat[JOINT_SLOTS*12];
      int          base_mat[JOINT_SLOTS*12];
      rsp_type     rows_due[$];
      int          errors;
      int          rows_seen;
      longint      atan_turns[30] = '{
         536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
         10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886, 83443,
         41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163, 81, 41, 20,
         10, 5, 3, 1};

      function new();
         joint_lim = 7;
         errors    = 0;
         rows_seen = 0;
      endfunction

      function void set_count(logic [3:0] v);
         joint_lim = v;
      endfunction

      function int pending();
         return rows_due.size();
      endfunction

      function int clip32(longint x);
         if (x > 64'sd2147483647) return 32'sh7FFF_FFFF;
         if (x < -64'sd2147483648) return 32'sh8000_0000;
         return int'(x);
      endfunction

      // Q16.16 product, rounded half up
      function longint qprod(int a, int b);
         return (longint'(a) * longint'(b) + 64'sd32768) >>> 16;
      endfunction

      function void sin_cos(int ang, output int s, output int c);
         longint     q, z, x, y, dx, dy;
         logic [31:0] u, t;
         bit          flip;
         q = (longint'(ang) * 64'sd683565276) >>> 16;
         u = q[31:0];
         t = u + 32'h4000_0000;
         flip = t[31];
         if (flip) u = u + 32'h8000_0000;
         z = longint'(signed'(u));
         x = 64'sd652032874;
         y = 0;
         for (int i = 0; i < CORDIC_STEPS; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0) begin
               x = x - dx; y = y + dy; z = z - atan_turns[i];
            end else begin
               x = x + dx; y = y - dy; z = z + atan_turns[i];
            end
         end
         x = (x + 8192) >>> 14;
         y = (y + 8192) >>> 14;
         if (flip) begin
            x = -x; y = -y;
         end
         c = clip32(x);
         s = clip32(y);
      endfunction

      function void form_link(int j, int deg);
         longint rad;
         int     theta, s, c, sa, ca, b;
         b     = j * 12;
         rad   = (longint'(deg) * 64'sd74961321 + 64'sd2147483648) >>> 32;
         theta = clip32(longint'(dh_words[j*4+FIELD_OFFSET]) + rad);
         sin_cos(theta, s, c);
         sin_cos(dh_words[j*4+FIELD_ALPHA], sa, ca);
         link_mat[b+0]  = c;
         link_mat[b+1]  = clip32(-longint'(clip32(qprod(s, ca))));
         link_mat[b+2]  = clip32(qprod(s, sa));
         link_mat[b+3]  = clip32(qprod(dh_words[j*4+FIELD_A], c));
         link_mat[b+4]  = s;
         link_mat[b+5]  = clip32(qprod(c, ca));
         link_mat[b+6]  = clip32(-longint'(clip32(qprod(c, sa))));
         link_mat[b+7]  = clip32(qprod(dh_words[j*4+FIELD_A], s));
         link_mat[b+8]  = 0;
         link_mat[b+9]  = sa;
         link_mat[b+10] = ca;
         link_mat[b+11] = dh_words[j*4+FIELD_D];
      endfunction

      function void chain_joint(int j);
         longint acc;
         int     pb;
         if (j == 0) begin
            for (int k = 0; k < 12; k++) base_mat[k] = link_mat[k];
            return;
         end
         pb = (j - 1) * 12;
         for (int r = 0; r < 3; r++)
            for (int c = 0; c < 4; c++) begin
               acc = (c == 3) ? longint'(base_mat[pb+r*4+3]) : 0;
               for (int k = 0; k < 3; k++)
                  acc += qprod(base_mat[pb+r*4+k], link_mat[j*12+k*4+c]);
               base_mat[j*12+r*4+c] = clip32(acc);
            end
      endfunction

      function void note_input(req_type rq);
         int      j, cnt, b;
         rsp_type e;
         j = rq.joint_index;
         case (rq.mode)
            MODE_LOAD:  dh_words[j*4+rq.dh_field] = rq.value;
            MODE_ANGLE: form_link(j, rq.value);
            MODE_CHAIN: begin
               cnt = (joint_lim > JOINT_SLOTS) ? JOINT_SLOTS : joint_lim;
               for (int i = j; i < cnt; i++) begin
                  chain_joint(i);
                  for (int r = 0; r < 3; r++) begin
                     b           = i * 12 + r * 4;
                     e.out_joint = i[2:0];
                     e.out_row   = r[1:0];
                     e.col0      = base_mat[b];
                     e.col1      = base_mat[b+1];
                     e.col2      = base_mat[b+2];
                     e.col3      = base_mat[b+3];
                     e.last      = (i + 1 == cnt) && (r == ROW_LAST);
                     rows_due.push_back(e);
                  end
               end
            end
            default: ;  // unused mode: ignored
         endcase
      endfunction

      function void cmp(string fname, longint want, longint got);
         if (want != got) begin
            errors++;
            $display("%0t: mismatch %s expected %0d actual %0d", $realtime, fname, want, got);
         end
      endfunction

      function void check(rsp_type got);
         rsp_type e;
         rows_seen++;
         if (rows_due.size() == 0) begin
            errors++;
            $display("%0t: unexpected row expected none actual %p", $realtime, got);
            return;
         end
         e = rows_due.pop_front();
         cmp("out_joint", e.out_joint, got.out_joint);
         cmp("out_row", e.out_row, got.out_row);
         cmp("col0", e.col0, got.col0);
         cmp("col1", e.col1, got.col1);
         cmp("col2", e.col2, got.col2);
         cmp("col3", e.col3, got.col3);
         cmp("last", e.last, got.last);
      endfunction
   endclass

   // --------------------------------------------------------------------
   // signals and block under test
   // --------------------------------------------------------------------
   logic       clock;
   logic       reset;
   logic       req_valid, req_ready;
   req_type    req_data;
   logic       rsp_valid, rsp_ready;
   rsp_type    rsp_data;
   logic       csr_valid, csr_ready;
   logic [3:0] csr_data;

   fk_scoreboard sb = new();

   // generator bookkeeping: which stores hold defined data
   bit [3:0] dh_mask[8];
   bit       link_ok[8];
   bit       base_ok[8];
   int       eff_count;
   int       items_sent;
   int       settings_done;
   bit       quiet;

   dh_forward_kinematics_chain uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data)
   );

   always begin
      clock = 1'b1; #5;
      clock = 1'b0; #5;
   end

   // --------------------------------------------------------------------
   // driver tasks; each returns right after a rising edge
   // --------------------------------------------------------------------
   task automatic send_item(logic [1:0] md, logic [2:0] jx, logic [1:0] fld, int val);
      req_type rq;
      rq.mode        = md;
      rq.joint_index = jx;
      rq.dh_field    = fld;
      rq.value       = val;
      if (!quiet && $urandom_range(0, 5) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 7)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= rq;
      do @(posedge clock); while (!req_ready);
      sb.note_input(rq);
      items_sent++;
      // track which entries are now defined
      case (md)
         MODE_LOAD:  dh_mask[jx][fld] = 1'b1;
         MODE_ANGLE: link_ok[jx] = 1'b1;
         MODE_CHAIN: for (int i = jx; i < eff_count; i++) base_ok[i] = 1'b1;
         default: ;
      endcase
   endtask

   // wait until every row is back, then give the sequencer time to settle
   task automatic drain();
      req_valid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (1000) @(posedge clock);
   endtask

   task automatic write_count(logic [3:0] v);
      drain();
      csr_valid <= 1'b1;
      csr_data  <= v;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      sb.set_count(v);
      eff_count = (v > JOINT_SLOTS) ? JOINT_SLOTS : v;
      settings_done++;
   endtask

   function automatic int rand_word();
      if ($urandom_range(0, 7) == 0) return int'($urandom);
      return int'($urandom_range(0, 786432)) - 393216;  // about +-6.0
   endfunction

   function automatic int rand_deg();
      if ($urandom_range(0, 7) == 0) return int'($urandom);
      return int'($urandom_range(0, 52428800)) - 26214400;  // about +-400 deg
   endfunction

   function automatic bit chain_safe(int s);
      if (s >= eff_count) return 1'b1;  // emits nothing, reads nothing
      if (s > 0 && !base_ok[s-1]) return 1'b0;
      for (int k = s; k < eff_count; k++)
         if (!link_ok[k]) return 1'b0;
      return 1'b1;
   endfunction

   // angle on a joint, loading any DH word that is still undefined first
   task automatic set_angle(int j, int deg);
      for (int f = 0; f < 4; f++)
         if (!dh_mask[j][f]) send_item(MODE_LOAD, j[2:0], f[1:0], rand_word());
      send_item(MODE_ANGLE, j[2:0], 2'd0, deg);
   endtask

   task automatic random_chain();
      int s;
      s = (eff_count == 0) ? $urandom_range(0, 7) : $urandom_range(0, eff_count - 1);
      if (!chain_safe(s)) begin
         for (int k = 0; k < eff_count; k++)
            if (!link_ok[k]) set_angle(k, rand_deg());
         if (!chain_safe(s)) s = 0;
      end
      send_item(MODE_CHAIN, s[2:0], 2'($urandom), int'($urandom));
   endtask

   task automatic random_step();
      int k, j;
      k = $urandom_range(0, 99);
      j = $urandom_range(0, JOINT_SLOTS - 1);
      if (k < 35)
         set_angle(j, rand_deg());
      else if (k < 65)
         random_chain();
      else if (k < 80)
         send_item(MODE_LOAD, j[2:0], 2'($urandom), rand_word());
      else if (k < 88)
         send_item(MODE_SPARE, 3'($urandom), 2'($urandom), int'($urandom));  // noise
      else if (k < 94 && eff_count < JOINT_SLOTS)
         send_item(MODE_CHAIN, 3'($urandom_range(eff_count, 7)), 2'd0, 0);
      else
         set_angle(j, int'($urandom));
   endtask

   // --------------------------------------------------------------------
   // result side: random back-pressure, checked on every handshake
   // --------------------------------------------------------------------
   initial begin
      rsp_ready <= 1'b0;
      @(negedge reset);
      @(posedge clock);
      rsp_ready <= 1'b1;
      forever begin
         @(posedge clock);
         if (!quiet && $urandom_range(0, 7) == 0) begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge clock);
            rsp_ready <= 1'b1;
         end
      end
   end

   always @(posedge clock)
      if (!reset && rsp_valid && rsp_ready) sb.check(rsp_data);

   // --------------------------------------------------------------------
   // main sequence
   // --------------------------------------------------------------------
   initial begin
      logic [3:0] phase_count[8];
      phase_count = '{4'd8, 4'd15, 4'd0, 4'd3, 4'd1, 4'd7, 4'd8, 4'd5};
      reset     <= 1'b1;
      req_valid <= 1'b0;
      req_data  <= '0;
      csr_valid <= 1'b0;
      csr_data  <= '0;
      eff_count  = 7;
      items_sent = 0;
      settings_done = 0;
      quiet = 1'b0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: single joint with extreme words and angles
      write_count(4'd1);
      send_item(MODE_LOAD, 3'd0, FIELD_D, 32'sh7FFF_FFFF);
      send_item(MODE_LOAD, 3'd0, FIELD_A, 32'sh8000_0000);
      send_item(MODE_LOAD, 3'd0, FIELD_ALPHA, 32'sh0001_921F);   // pi/2
      send_item(MODE_LOAD, 3'd0, FIELD_OFFSET, 32'sh0000_0000);
      send_item(MODE_ANGLE, 3'd0, 2'd0, 32'sh7FFF_FFFF);
      send_item(MODE_CHAIN, 3'd0, 2'd0, 0);
      send_item(MODE_ANGLE, 3'd0, 2'd0, 32'sh8000_0000);
      send_item(MODE_CHAIN, 3'd0, 2'd0, 0);
      send_item(MODE_ANGLE, 3'd0, 2'd0, 180 << 16);              // flip region
      send_item(MODE_CHAIN, 3'd0, 2'd0, 0);
      send_item(MODE_SPARE, 3'd7, 2'd3, -1);                     // unused mode
      send_item(MODE_CHAIN, 3'd1, 2'd0, 0);                      // start past count
      // second joint, small lengths, then a two-joint chain
      send_item(MODE_LOAD, 3'd1, FIELD_D, 32'sh0001_0000);
      send_item(MODE_LOAD, 3'd1, FIELD_A, 32'sh0002_8000);
      send_item(MODE_LOAD, 3'd1, FIELD_ALPHA, 32'shFFFE_6DE1);   // -pi/2
      send_item(MODE_LOAD, 3'd1, FIELD_OFFSET, 32'sh0000_C910);
      send_item(MODE_ANGLE, 3'd1, 2'd0, 90 << 16);
      send_item(MODE_ANGLE, 3'd0, 2'd0, -(45 << 16));
      write_count(4'd2);
      send_item(MODE_CHAIN, 3'd0, 2'd0, 0);
      send_item(MODE_CHAIN, 3'd1, 2'd0, 0);

      // random phases, one joint_count setting each; last phase runs flat out
      for (int p = 0; p < 8; p++) begin
         write_count(phase_count[p]);
         if (p == 7) quiet = 1'b1;
         while (items_sent < 22 + (p + 1) * 56) begin
            random_step();
            // hold-off: sender waits for every row now and then
            if ($urandom_range(0, 99) == 0) drain();
         end
      end
      drain();

      $display("Covered %0d items over %0d joint_count settings, %0d rows compared.",
               items_sent, settings_done, sb.rows_seen);
      $display("Loads, angles, chain updates and ignored items with back-pressure on both sides.");
      if (sb.errors == 0 && sb.pending() == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

   // watchdog
   initial begin
      #40ms;
      $display("TEST FAILED");
      $finish;
   end

endmodule
